// ===== rtl/core/fwd_pkg.sv =====
package fwd_pkg;

  localparam int ROUTE_ENTRIES     = 16;
  localparam int PORTS             = 4;
  localparam int NEIGHBOR_KEY_BITS = 16;

  localparam logic [31:0] RIP_GROUP_RESET = 32'hE000_0009;
  localparam logic [7:0]  PROTO_ICMP      = 8'd1;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [15:0] ICMP_ECHO_REQ   = 16'd8;
  localparam logic [15:0] UDP_PORT_ECHO   = 16'd7;
  localparam logic [15:0] UDP_PORT_TIME   = 16'd37;
  localparam logic [15:0] UDP_PORT_RIP    = 16'd520;

  typedef enum logic [1:0] {
    MODE_ROUTE  = 2'd0,
    MODE_NEIGH  = 2'd1,
    MODE_IFACE  = 2'd2,
    MODE_PACKET = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ACT_WRITTEN  = 4'd0,
    ACT_IGNORED  = 4'd1,
    ACT_ECHO     = 4'd2,
    ACT_UDP_ECHO = 4'd3,
    ACT_TIME     = 4'd4,
    ACT_RIP      = 4'd5,
    ACT_TTL      = 4'd6,
    ACT_NO_ROUTE = 4'd7,
    ACT_FORWARD  = 4'd8,
    ACT_MISS     = 4'd9
  } action_e;

  // route entry as written into one cell
  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [1:0]  port;
  } route_t;

  // search word handed from cell to cell
  typedef struct packed {
    logic        vld;
    logic [31:0] dest;
    logic        found;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [1:0]  port;
  } search_t;

  // sort a local packet by protocol and service
  function automatic action_e classify_local(logic [7:0] proto, logic [15:0] service);
    action_e act;
    act = ACT_IGNORED;
    if (proto == PROTO_ICMP) begin
      if (service == ICMP_ECHO_REQ) act = ACT_ECHO;
    end else if (proto == PROTO_UDP) begin
      if (service == UDP_PORT_ECHO) act = ACT_UDP_ECHO;
      else if (service == UDP_PORT_TIME) act = ACT_TIME;
      else if (service == UDP_PORT_RIP) act = ACT_RIP;
    end
    return act;
  endfunction

endpackage

// ===== rtl/core/ipv4_forwarding_decision_core.sv =====
// IPv4 forwarding decision over pre-parsed header fields.
// Input channel (in_valid_i/in_ready_o) carries one word per operation,
// selected by mode_i: route write, neighbor write, interface write or packet.
// Output channel (out_valid_o/out_ready_i) returns one result word for each
// input word, in order. The config channel (cfg_valid_i/cfg_ready_o) writes
// the RIP group address and is always ready.
// Words are handled one at a time. A packet that needs a route walks the chain
// of route cells, one cell a cycle, and then reads the neighbor memory; a write
// or a local/expired packet goes straight to its result. The next word is
// accepted the cycle after the result is loaded into the output register.
// After reset the neighbor valid memory is cleared one entry a cycle, over all
// 2**NEIGHBOR_KEY_BITS entries (65536); no input word is accepted meanwhile.
// Route and interface tables come up empty, the RIP group at 224.0.0.9.
// A stalled output holds its word; the block keeps the next result pending
// and does not take a new input word until that result moves to the output.
module ipv4_forwarding_decision_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] entry_addr_i,
  input  logic [31:0] entry_mask_i,
  input  logic [1:0]  entry_port_i,
  input  logic [31:0] entry_gateway_i,
  input  logic [47:0] entry_mac_i,
  input  logic [31:0] dest_addr_i,
  input  logic [7:0]  protocol_i,
  input  logic [15:0] service_i,
  input  logic [7:0]  ttl_i,
  input  logic [1:0]  in_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  action_o,
  output logic [1:0]  out_port_o,
  output logic [31:0] hop_addr_o,
  output logic [47:0] dest_mac_o,
  output logic [7:0]  new_ttl_o,
  output logic [1:0]  reply_port_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int KeyBits = fwd_pkg::NEIGHBOR_KEY_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_WALK, S_LOOK, S_FIN
  } state_e;

  state_e state_q;

  // captured input word
  fwd_pkg::mode_e mode_q;
  logic [3:0]  slot_q;
  logic [31:0] addr_q, mask_q, gw_q, dest_q;
  logic [1:0]  eport_q, inport_q;
  logic [47:0] mac_q;
  logic [7:0]  proto_q, ttl_q;
  logic [15:0] service_q;

  // pending result and output register
  fwd_pkg::action_e res_act_q, out_act_q;
  logic [1:0]  res_oport_q, res_rport_q, out_oport_q, out_rport_q;
  logic [31:0] res_nhop_q, out_nhop_q;
  logic [47:0] res_mac_q, out_mac_q;
  logic [7:0]  res_ttl_q, out_ttl_q;
  logic        out_vld_q;

  logic [KeyBits-1:0] clr_cnt_q;
  logic [31:0] rip_q;
  logic [31:0] if_addr_q [fwd_pkg::PORTS];
  logic [31:0] if_mask_q [fwd_pkg::PORTS];
  logic        if_vld_q  [fwd_pkg::PORTS];

  logic             in_acc, is_local, route_wr, chain_go;
  logic [7:0]       ttl_dec;
  logic [31:0]      nhop_sel;
  fwd_pkg::route_t  wr_entry;
  fwd_pkg::search_t srch_in, srch_out;
  logic             nm_we_mac, nm_we_vld, nm_wvld, nm_re;
  logic [KeyBits-1:0] nm_waddr;
  logic [47:0]      nm_rmac;
  logic             nm_rvld;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // rip group register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rip_q <= fwd_pkg::RIP_GROUP_RESET;
    end else if (cfg_valid_i) begin
      rip_q <= cfg_data_i;
    end
  end

  // capture input word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q    <= fwd_pkg::mode_e'(mode_i);
      slot_q    <= slot_i;
      addr_q    <= entry_addr_i;
      mask_q    <= entry_mask_i;
      eport_q   <= entry_port_i;
      gw_q      <= entry_gateway_i;
      mac_q     <= entry_mac_i;
      dest_q    <= dest_addr_i;
      proto_q   <= protocol_i;
      service_q <= service_i;
      ttl_q     <= ttl_i;
      inport_q  <= in_port_i;
    end
  end

  // interface table
  for (genvar p = 0; p < fwd_pkg::PORTS; p++) begin : g_iface
    logic if_wr;
    assign if_wr = (state_q == S_EXEC) && (mode_q == fwd_pkg::MODE_IFACE) &&
                   (int'(slot_q) == p);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        if_vld_q[p] <= 1'b0;
      end else if (if_wr) begin
        if_vld_q[p] <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (if_wr) begin
        if_addr_q[p] <= addr_q;
        if_mask_q[p] <= mask_q;
      end
    end
  end

  // local address check over the rip group and all interfaces
  always_comb begin
    is_local = (dest_q == rip_q);
    for (int p = 0; p < fwd_pkg::PORTS; p++) begin
      if (if_vld_q[p] && ((dest_q == if_addr_q[p]) ||
          (dest_q == ((if_addr_q[p] & if_mask_q[p]) | ~if_mask_q[p])))) begin
        is_local = 1'b1;
      end
    end
  end

  assign ttl_dec = ttl_q - 8'd1;

  // route chain
  assign route_wr = (state_q == S_EXEC) && (mode_q == fwd_pkg::MODE_ROUTE);
  assign chain_go = (state_q == S_EXEC) && (mode_q == fwd_pkg::MODE_PACKET) &&
                    !is_local && (ttl_dec != 8'd0);
  assign wr_entry = '{prefix: addr_q, mask: mask_q, gateway: gw_q, port: eport_q};

  always_comb begin
    srch_in         = '0;
    srch_in.vld     = chain_go;
    srch_in.dest    = dest_q;
  end

  fwd_route_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (route_wr),
    .wr_slot_i  (slot_q),
    .wr_entry_i (wr_entry),
    .srch_i     (srch_in),
    .srch_o     (srch_out)
  );

  // neighbor memory: clear pass after reset, then writes and lookups
  assign nhop_sel  = (srch_out.gateway == 32'd0) ? srch_out.dest : srch_out.gateway;
  assign nm_we_mac = (state_q == S_EXEC) && (mode_q == fwd_pkg::MODE_NEIGH);
  assign nm_we_vld = (state_q == S_CLEAR) || nm_we_mac;
  assign nm_wvld   = (state_q != S_CLEAR);
  assign nm_waddr  = (state_q == S_CLEAR) ? clr_cnt_q : gw_q[KeyBits-1:0];
  assign nm_re     = (state_q == S_WALK) && srch_out.vld;

  fwd_neigh_mem u_neigh (
    .clk_i    (clk_i),
    .we_mac_i (nm_we_mac),
    .we_vld_i (nm_we_vld),
    .waddr_i  (nm_waddr),
    .wmac_i   (mac_q),
    .wvld_i   (nm_wvld),
    .re_i     (nm_re),
    .raddr_i  (nhop_sel[KeyBits-1:0]),
    .rmac_o   (nm_rmac),
    .rvld_o   (nm_rvld)
  );

  // sequencer with pending result and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_vld_q   <= 1'b0;
      res_act_q   <= fwd_pkg::ACT_WRITTEN;
      res_oport_q <= '0;
      res_rport_q <= '0;
      res_nhop_q  <= '0;
      res_mac_q   <= '0;
      res_ttl_q   <= '0;
      out_act_q   <= fwd_pkg::ACT_WRITTEN;
      out_oport_q <= '0;
      out_rport_q <= '0;
      out_nhop_q  <= '0;
      out_mac_q   <= '0;
      out_ttl_q   <= '0;
    end else begin
      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (&clr_cnt_q) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) state_q <= S_EXEC;
        end
        S_EXEC: begin
          res_act_q   <= fwd_pkg::ACT_WRITTEN;
          res_oport_q <= '0;
          res_nhop_q  <= '0;
          res_mac_q   <= '0;
          res_ttl_q   <= '0;
          res_rport_q <= '0;
          state_q     <= S_FIN;
          if (mode_q == fwd_pkg::MODE_PACKET) begin
            res_rport_q <= inport_q;
            if (is_local) begin
              res_act_q <= fwd_pkg::classify_local(proto_q, service_q);
            end else begin
              res_ttl_q <= ttl_dec;
              if (ttl_dec == 8'd0) res_act_q <= fwd_pkg::ACT_TTL;
              else state_q <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (srch_out.vld) begin
            if (!srch_out.found) begin
              res_act_q <= fwd_pkg::ACT_NO_ROUTE;
              state_q   <= S_FIN;
            end else begin
              res_oport_q <= srch_out.port;
              res_nhop_q  <= nhop_sel;
              state_q     <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (nm_rvld) begin
            res_act_q <= fwd_pkg::ACT_FORWARD;
            res_mac_q <= nm_rmac;
          end else begin
            res_act_q <= fwd_pkg::ACT_MISS;
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_vld_q || out_ready_i) begin
            out_vld_q   <= 1'b1;
            out_act_q   <= res_act_q;
            out_oport_q <= res_oport_q;
            out_rport_q <= res_rport_q;
            out_nhop_q  <= res_nhop_q;
            out_mac_q   <= res_mac_q;
            out_ttl_q   <= res_ttl_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_vld_q;
  assign action_o     = out_act_q;
  assign out_port_o   = out_oport_q;
  assign hop_addr_o   = out_nhop_q;
  assign dest_mac_o   = out_mac_q;
  assign new_ttl_o    = out_ttl_q;
  assign reply_port_o = out_rport_q;

endmodule

// ===== rtl/core/fwd_route_cell.sv =====
module fwd_route_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  fwd_pkg::route_t  wr_entry_i,
  input  fwd_pkg::search_t srch_i,
  output fwd_pkg::search_t srch_o
);

  logic            valid_q;
  fwd_pkg::route_t entry_q;
  fwd_pkg::search_t srch_d, srch_q;
  logic            hit;

  // entry storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entry_q <= wr_entry_i;
    end
  end

  // match and keep the longer mask, earlier cell wins a tie
  always_comb begin
    hit = valid_q && ((srch_i.dest & entry_q.mask) == entry_q.prefix) &&
          (!srch_i.found || (entry_q.mask > srch_i.mask));
    srch_d = srch_i;
    if (hit) begin
      srch_d.found   = 1'b1;
      srch_d.mask    = entry_q.mask;
      srch_d.gateway = entry_q.gateway;
      srch_d.port    = entry_q.port;
    end
  end

  // hand the search word to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_q <= '0;
    end else begin
      srch_q <= srch_d;
    end
  end

  assign srch_o = srch_q;

endmodule

// ===== rtl/core/fwd_route_chain.sv =====
module fwd_route_chain (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [3:0]       wr_slot_i,
  input  fwd_pkg::route_t  wr_entry_i,
  input  fwd_pkg::search_t srch_i,
  output fwd_pkg::search_t srch_o
);

  fwd_pkg::search_t link [fwd_pkg::ROUTE_ENTRIES+1];

  assign link[0] = srch_i;

  // one cell per route slot
  for (genvar i = 0; i < fwd_pkg::ROUTE_ENTRIES; i++) begin : g_cell
    logic cell_wr;
    assign cell_wr = wr_i && (int'(wr_slot_i) == i);

    fwd_route_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_i       (cell_wr),
      .wr_entry_i (wr_entry_i),
      .srch_i     (link[i]),
      .srch_o     (link[i+1])
    );
  end

  assign srch_o = link[fwd_pkg::ROUTE_ENTRIES];

endmodule

// ===== rtl/core/fwd_neigh_mem.sv =====
module fwd_neigh_mem (
  input  logic                                 clk_i,
  input  logic                                 we_mac_i,
  input  logic                                 we_vld_i,
  input  logic [fwd_pkg::NEIGHBOR_KEY_BITS-1:0] waddr_i,
  input  logic [47:0]                          wmac_i,
  input  logic                                 wvld_i,
  input  logic                                 re_i,
  input  logic [fwd_pkg::NEIGHBOR_KEY_BITS-1:0] raddr_i,
  output logic [47:0]                          rmac_o,
  output logic                                 rvld_o
);

  localparam int Depth = 1 << fwd_pkg::NEIGHBOR_KEY_BITS;

  logic [47:0] mac_mem [Depth];
  logic        vld_mem [Depth];
  logic [47:0] rmac_q;
  logic        rvld_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_mac_i) mac_mem[waddr_i] <= wmac_i;
    if (we_vld_i) vld_mem[waddr_i] <= wvld_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rmac_q <= mac_mem[raddr_i];
      rvld_q <= vld_mem[raddr_i];
    end
  end

  assign rmac_o = rmac_q;
  assign rvld_o = rvld_q;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

  // one input word and one result word
  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  slot;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [1:0]  port;
    logic [31:0] gw;
    logic [47:0] mac;
    logic [31:0] dest;
    logic [7:0]  proto;
    logic [15:0] service;
    logic [7:0]  ttl;
    logic [1:0]  in_port;
  } word_t;

  typedef struct {
    logic [3:0]  action;
    logic [1:0]  out_port;
    logic [31:0] hop_addr;
    logic [47:0] dest_mac;
    logic [7:0]  new_ttl;
    logic [1:0]  reply_port;
  } decision_t;

  localparam int WATCHDOG_CYCLES = 200000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int KEY_BITS        = fwd_pkg::NEIGHBOR_KEY_BITS;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [3:0]  slot_i = '0;
  logic [31:0] entry_addr_i = '0;
  logic [31:0] entry_mask_i = '0;
  logic [1:0]  entry_port_i = '0;
  logic [31:0] entry_gateway_i = '0;
  logic [47:0] entry_mac_i = '0;
  logic [31:0] dest_addr_i = '0;
  logic [7:0]  protocol_i = '0;
  logic [15:0] service_i = '0;
  logic [7:0]  ttl_i = '0;
  logic [1:0]  in_port_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  action_o;
  logic [1:0]  out_port_o;
  logic [31:0] hop_addr_o;
  logic [47:0] dest_mac_o;
  logic [7:0]  new_ttl_o;
  logic [1:0]  reply_port_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  ipv4_forwarding_decision_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .slot_i, .entry_addr_i,
    .entry_mask_i, .entry_port_i, .entry_gateway_i, .entry_mac_i, .dest_addr_i,
    .protocol_i, .service_i, .ttl_i, .in_port_i, .out_valid_o, .out_ready_i,
    .action_o, .out_port_o, .hop_addr_o, .dest_mac_o, .new_ttl_o, .reply_port_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the forwarding tables
  logic [31:0] rip_addr;
  logic [31:0] rt_prefix [fwd_pkg::ROUTE_ENTRIES];
  logic [31:0] rt_mask [fwd_pkg::ROUTE_ENTRIES];
  logic [31:0] rt_gw [fwd_pkg::ROUTE_ENTRIES];
  logic [1:0]  rt_port [fwd_pkg::ROUTE_ENTRIES];
  bit          rt_vld [fwd_pkg::ROUTE_ENTRIES];
  logic [47:0] nb_mac [2**KEY_BITS];
  bit          nb_vld [2**KEY_BITS];
  logic [31:0] if_addr [fwd_pkg::PORTS];
  logic [31:0] if_mask [fwd_pkg::PORTS];
  bit          if_vld [fwd_pkg::PORTS];

  decision_t   pending_decisions[$];
  int          errors = 0;
  int          n_words = 0;
  int          n_results = 0;
  int          n_cfg = 0;
  int          n_forwarded = 0;
  bit          calm = 1'b0;
  int          quiet_cycles = 0;

  initial begin
    rip_addr = fwd_pkg::RIP_GROUP_RESET;
    for (int i = 0; i < fwd_pkg::ROUTE_ENTRIES; i++) rt_vld[i] = 1'b0;
    for (int i = 0; i < fwd_pkg::PORTS; i++) if_vld[i] = 1'b0;
    for (int i = 0; i < 2**KEY_BITS; i++) nb_vld[i] = 1'b0;
  end

  // predict the decision for one word and update the tables
  function automatic decision_t decide(word_t w);
    decision_t r;
    bit        loc;
    bit        found;
    int        best;
    logic [31:0] bcast;
    logic [31:0] nh;
    r = '{fwd_pkg::ACT_WRITTEN, '0, '0, '0, '0, '0};
    case (w.mode)
      fwd_pkg::MODE_ROUTE: begin
        rt_prefix[w.slot] = w.addr;
        rt_mask[w.slot] = w.mask;
        rt_gw[w.slot] = w.gw;
        rt_port[w.slot] = w.port;
        rt_vld[w.slot] = 1'b1;
      end
      fwd_pkg::MODE_NEIGH: begin
        nb_mac[w.gw[KEY_BITS-1:0]] = w.mac;
        nb_vld[w.gw[KEY_BITS-1:0]] = 1'b1;
      end
      fwd_pkg::MODE_IFACE: begin
        if (w.slot < fwd_pkg::PORTS) begin
          if_addr[w.slot] = w.addr;
          if_mask[w.slot] = w.mask;
          if_vld[w.slot] = 1'b1;
        end
      end
      default: begin
        r.reply_port = w.in_port;
        loc = (w.dest == rip_addr);
        for (int i = 0; i < fwd_pkg::PORTS; i++) begin
          bcast = (if_addr[i] & if_mask[i]) | ~if_mask[i];
          if (if_vld[i] && (w.dest == if_addr[i] || w.dest == bcast)) loc = 1'b1;
        end
        if (loc) begin
          r.action = fwd_pkg::ACT_IGNORED;
          if (w.proto == fwd_pkg::PROTO_ICMP && w.service == fwd_pkg::ICMP_ECHO_REQ)
            r.action = fwd_pkg::ACT_ECHO;
          if (w.proto == fwd_pkg::PROTO_UDP) begin
            if (w.service == fwd_pkg::UDP_PORT_ECHO) r.action = fwd_pkg::ACT_UDP_ECHO;
            else if (w.service == fwd_pkg::UDP_PORT_TIME) r.action = fwd_pkg::ACT_TIME;
            else if (w.service == fwd_pkg::UDP_PORT_RIP) r.action = fwd_pkg::ACT_RIP;
          end
        end else begin
          r.new_ttl = w.ttl - 8'd1;
          if (r.new_ttl == 8'd0) begin
            r.action = fwd_pkg::ACT_TTL;
          end else begin
            found = 1'b0;
            best = 0;
            for (int i = 0; i < fwd_pkg::ROUTE_ENTRIES; i++) begin
              if (rt_vld[i] && (w.dest & rt_mask[i]) == rt_prefix[i] &&
                  (!found || rt_mask[i] > rt_mask[best])) begin
                found = 1'b1;
                best = i;
              end
            end
            if (!found) begin
              r.action = fwd_pkg::ACT_NO_ROUTE;
            end else begin
              r.out_port = rt_port[best];
              nh = (rt_gw[best] == 32'd0) ? w.dest : rt_gw[best];
              r.hop_addr = nh;
              if (nb_vld[nh[KEY_BITS-1:0]]) begin
                r.action = fwd_pkg::ACT_FORWARD;
                r.dest_mac = nb_mac[nh[KEY_BITS-1:0]];
              end else begin
                r.action = fwd_pkg::ACT_MISS;
              end
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("result %0d: %s got %0h, expected %0h", n_results, field, got, want);
  endtask

  // send one word, unless calm is set at times with a random gap in front of it
  task automatic send_word(word_t w);
    if (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= w.mode;
    slot_i <= w.slot;
    entry_addr_i <= w.addr;
    entry_mask_i <= w.mask;
    entry_port_i <= w.port;
    entry_gateway_i <= w.gw;
    entry_mac_i <= w.mac;
    dest_addr_i <= w.dest;
    protocol_i <= w.proto;
    service_i <= w.service;
    ttl_i <= w.ttl;
    in_port_i <= w.in_port;
    do @(posedge clk_i); while (!in_ready_o);
    pending_decisions.push_back(decide(w));
    n_words++;
    if (w.mode == fwd_pkg::MODE_PACKET && pending_decisions[$].action == fwd_pkg::ACT_FORWARD)
      n_forwarded++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // rip group register write, only with the block idle
  task automatic write_rip(logic [31:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    rip_addr = value;
    n_cfg++;
  endtask

  function automatic logic [31:0] prefix_mask(int len);
    return (len == 0) ? 32'd0 : (32'hffff_ffff << (32 - len));
  endfunction

  function automatic word_t blank(logic [1:0] mode);
    word_t w;
    w = '{mode, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0};
    return w;
  endfunction

  function automatic word_t pkt(logic [31:0] dest, logic [7:0] proto, logic [15:0] svc,
                                logic [7:0] ttl);
    word_t w;
    w = blank(fwd_pkg::MODE_PACKET);
    w.dest = dest;
    w.proto = proto;
    w.service = svc;
    w.ttl = ttl;
    w.in_port = 2'($urandom_range(3));
    return w;
  endfunction

  function automatic word_t route(logic [3:0] slot, logic [31:0] pfx, logic [31:0] mask,
                                  logic [31:0] gw, logic [1:0] port);
    word_t w;
    w = blank(fwd_pkg::MODE_ROUTE);
    w.slot = slot;
    w.addr = pfx;
    w.mask = mask;
    w.gw = gw;
    w.port = port;
    return w;
  endfunction

  // tables, local classes, ttl and route corner cases
  task automatic test_directed();
    word_t w;
    w = blank(fwd_pkg::MODE_IFACE);
    w.slot = 4'd0; w.addr = 32'h0a00_0001; w.mask = 32'hffff_ff00;
    send_word(w);
    w.slot = 4'd3; w.addr = 32'hc0a8_0101; w.mask = 32'hffff_0000; w.in_port = 2'd3;
    send_word(w);
    // interface number past the last port is dropped
    w.slot = 4'd15; w.addr = 32'h0505_0505; w.mask = 32'hffff_ffff;
    send_word(w);
    send_word(route(4'd15, 32'h0, 32'h0, 32'h0a00_0002, 2'd3));
    send_word(route(4'd1, 32'h1400_0000, 32'hff00_0000, 32'h0, 2'd1));
    send_word(route(4'd2, 32'h1401_0000, 32'hffff_0000, 32'h0a00_00fe, 2'd2));
    // prefix outside its mask never matches
    send_word(route(4'd3, 32'h1e00_00ff, 32'hff00_0000, 32'h0, 2'd0));
    send_word(route(4'd0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 2'd3));
    w = blank(fwd_pkg::MODE_NEIGH);
    w.gw = 32'hffff_0002; w.mac = 48'hffff_ffff_ffff;
    send_word(w);
    w.gw = 32'h0000_00fe; w.mac = 48'h0012_3456_789a;
    send_word(w);
    send_word(pkt(32'h0a00_0001, fwd_pkg::PROTO_ICMP, 16'd8, 8'd64));
    send_word(pkt(32'h0a00_0001, fwd_pkg::PROTO_ICMP, 16'd0, 8'd64));
    send_word(pkt(32'h0a00_00ff, fwd_pkg::PROTO_UDP, 16'd7, 8'd1));
    send_word(pkt(32'hc0a8_ffff, fwd_pkg::PROTO_UDP, 16'd37, 8'd0));
    send_word(pkt(fwd_pkg::RIP_GROUP_RESET, fwd_pkg::PROTO_UDP, 16'd520, 8'd1));
    send_word(pkt(32'hc0a8_0101, fwd_pkg::PROTO_UDP, 16'hffff, 8'd9));
    send_word(pkt(32'hc0a8_0101, 8'd6, 16'd8, 8'd9));
    send_word(pkt(32'h1400_0005, 8'd6, 16'd80, 8'd1));
    send_word(pkt(32'h1400_0005, 8'd6, 16'd80, 8'd0));
    send_word(pkt(32'h1401_0203, fwd_pkg::PROTO_UDP, 16'd53, 8'd255));
    send_word(pkt(32'h1e00_00ff, 8'd6, 16'd80, 8'd2));
    send_word(pkt(32'hffff_ffff, 8'hff, 16'hffff, 8'hff));
    send_word(pkt(32'h0, 8'd0, 16'd0, 8'd2));
  endtask

  // rip group register over its extremes
  task automatic test_rip_group();
    logic [31:0] vals [4];
    vals = '{32'h0, 32'hffff_ffff, $urandom, fwd_pkg::RIP_GROUP_RESET};
    foreach (vals[i]) begin
      write_rip(vals[i]);
      send_word(pkt(vals[i], fwd_pkg::PROTO_UDP, 16'd520, 8'd5));
      send_word(pkt(vals[i] ^ 32'h1, fwd_pkg::PROTO_UDP, 16'd520, 8'd5));
    end
  endtask

  // random words; mostly packets aimed at the tables
  task automatic test_random(int count);
    word_t       w;
    int          sel;
    int          len;
    logic [15:0] keys [8];
    foreach (keys[i]) keys[i] = 16'($urandom);
    for (int n = 0; n < count; n++) begin
      calm = (n >= 300 && n < 500);
      if (n == 700) wait_drained();
      if (n == 1000) write_rip(32'he000_0000 | $urandom_range(255));
      w.mode = fwd_pkg::MODE_PACKET; w.slot = 4'($urandom); w.addr = $urandom;
      w.mask = $urandom;
      w.port = 2'($urandom); w.gw = $urandom; w.mac = {16'($urandom), $urandom};
      w.dest = $urandom; w.proto = 8'($urandom); w.service = 16'($urandom);
      w.ttl = 8'($urandom);
      w.in_port = 2'($urandom);
      len = $urandom_range(32);
      sel = $urandom_range(99);
      if (sel < 8) begin
        w.mode = fwd_pkg::MODE_ROUTE;
        if ($urandom_range(9) != 0) w.mask = prefix_mask(len);
        if ($urandom_range(9) != 0) w.addr = w.addr & w.mask;
        if ($urandom_range(2) == 0) w.gw = '0;
        else w.gw[15:0] = keys[$urandom_range(7)];
      end else if (sel < 14) begin
        w.mode = fwd_pkg::MODE_NEIGH;
        w.gw[15:0] = keys[$urandom_range(7)];
      end else if (sel < 18) begin
        w.mode = fwd_pkg::MODE_IFACE;
        if ($urandom_range(3) != 0) w.mask = prefix_mask(len);
      end else if (sel < 20) begin
        w.mode = 2'($urandom);
      end else begin
        sel = $urandom_range(fwd_pkg::ROUTE_ENTRIES - 1);
        sel = $urandom_range(9);
        if (sel < 5) begin
          sel = $urandom_range(fwd_pkg::ROUTE_ENTRIES - 1);
          if (rt_vld[sel]) w.dest = rt_prefix[sel] | (w.dest & ~rt_mask[sel]);
          if ($urandom_range(1) == 0) w.dest[15:0] = keys[$urandom_range(7)];
        end else if (sel < 7) begin
          sel = $urandom_range(fwd_pkg::PORTS - 1);
          if ($urandom_range(1) == 0) w.dest = if_addr[sel];
          else w.dest = (if_addr[sel] & if_mask[sel]) | ~if_mask[sel];
        end else if (sel == 7) begin
          w.dest = rip_addr;
        end
        case ($urandom_range(3))
          0: w.proto = fwd_pkg::PROTO_ICMP;
          1, 2: w.proto = fwd_pkg::PROTO_UDP;
          default: ;
        endcase
        case ($urandom_range(5))
          0: w.service = fwd_pkg::UDP_PORT_ECHO;
          1: w.service = fwd_pkg::ICMP_ECHO_REQ;
          2: w.service = fwd_pkg::UDP_PORT_TIME;
          3: w.service = fwd_pkg::UDP_PORT_RIP;
          default: ;
        endcase
        if ($urandom_range(15) == 0) w.ttl = 8'($urandom_range(1));
      end
      send_word(w);
    end
    calm = 1'b0;
  endtask

  // result stall pattern
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 22);
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    decision_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_decisions.size() == 0) begin
        report("unexpected word", 64'(action_o), 64'd0);
      end else begin
        e = pending_decisions.pop_front();
        if (action_o !== e.action)
          report("action", 64'(action_o), 64'(e.action));
        if (out_port_o !== e.out_port)
          report("out_port", 64'(out_port_o), 64'(e.out_port));
        if (hop_addr_o !== e.hop_addr)
          report("hop_addr", 64'(hop_addr_o), 64'(e.hop_addr));
        if (dest_mac_o !== e.dest_mac)
          report("dest_mac", 64'(dest_mac_o), 64'(e.dest_mac));
        if (new_ttl_o !== e.new_ttl)
          report("new_ttl", 64'(new_ttl_o), 64'(e.new_ttl));
        if (reply_port_o !== e.reply_port)
          report("reply_port", 64'(reply_port_o), 64'(e.reply_port));
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog expired with %0d results outstanding", pending_decisions.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_rip_group();
    test_random(1550);
    wait_drained();
    $display("covered %0d words (%0d forwarded with a neighbor hit), %0d results",
             n_words, n_forwarded, n_results);
    $display("with %0d rip group writes between drained stretches", n_cfg);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
